/* hw/rtl/dvrtu_pkg.sv */
// Package for the distance-vector route table update block.
// Holds table sizing, item and result types, action codes and table port structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dvrtu_pkg;

    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int SLOT_W        = 5;
    localparam int METRIC_W      = 4;

    localparam logic [31:0] METRIC_LIMIT = 32'd15;
    localparam logic [31:0] LOOPBACK_NET = 32'h7F00_0000;

    typedef enum logic [2:0] {
        ACT_ADDED      = 3'd0,
        ACT_REPLACED   = 3'd1,
        ACT_WORSE      = 3'd2,
        ACT_BAD_METRIC = 3'd3,
        ACT_LOOPBACK   = 3'd4,
        ACT_FULL       = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] route_network;
        logic [31:0] route_mask;
        logic [31:0] route_next_hop;
        logic [31:0] route_metric;
    } route_t;

    typedef struct packed {
        action_t             action;
        logic [SLOT_W-1:0]   slot;
    } result_t;

    // write port of the route table
    typedef struct packed {
        logic                en;
        logic [IDX_W-1:0]    addr;
        logic [31:0]         network;
        logic [31:0]         mask;
        logic [31:0]         gateway;
        logic [METRIC_W-1:0] metric;
    } tbl_wr_t;

    // registered read reply of the route table
    typedef struct packed {
        logic                valid;
        logic [31:0]         network;
        logic [METRIC_W-1:0] metric;
    } tbl_rd_t;

endpackage

`default_nettype wire

/* hw/rtl/dvrtu_table.sv */
// Route table storage: key memory, route data memory and per-entry valid flags.
// Depends on dvrtu_pkg. One read port with a registered reply, one write port.
`timescale 1ns / 1ps
`default_nettype none

module dvrtu_table
    import dvrtu_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output tbl_rd_t               rd,
    input  wire tbl_wr_t          wr
);

    typedef struct packed {
        logic [31:0]         network;
        logic [METRIC_W-1:0] metric;
    } key_t;

    typedef struct packed {
        logic [31:0] mask;
        logic [31:0] gateway;
    } route_data_t;

    key_t                     key_mem [TABLE_ENTRIES];
    route_data_t              data_mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg;
    key_t                     rd_key_reg;
    logic                     rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            key_mem[wr.addr]  <= '{network: wr.network, metric: wr.metric};
            data_mem[wr.addr] <= '{mask: wr.mask, gateway: wr.gateway};
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_key_reg   <= key_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd.valid   = rd_valid_reg;
    assign rd.network = rd_key_reg.network;
    assign rd.metric  = rd_key_reg.metric;

endmodule

`default_nettype wire

/* hw/rtl/distance_vector_route_table_update.sv */
// Top level of the distance-vector route table update block.
// Depends on dvrtu_pkg and dvrtu_table.
//
//  channel | ports                  | handshake
//  --------+------------------------+-----------------------------------
//  item in | start, busy, route     | taken when start && !busy
//  result  | done, result           | one-cycle strobe, cannot be stalled
//
// Loopback and bad-metric items go straight to the finishing step. Other
// items scan the table one entry a cycle through the key memory read port:
// a hit ends the scan at the matching slot, a miss scans every entry.
// busy stays high until the strobe cycle, in which a new item may already
// be taken.
// Reset clears the valid flags at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module distance_vector_route_table_update
    import dvrtu_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   start,
    output logic        busy,
    input  wire route_t route,
    output logic        done,
    output result_t     result
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam logic [CNT_W-1:0] PTR_END  = CNT_W'(TABLE_ENTRIES);

    state_t           state_reg,     state_next;
    route_t           item_reg,      item_next;
    logic [CNT_W-1:0] ptr_reg,       ptr_next;
    logic             rd_vld_reg,    rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg,    rd_idx_next;
    logic             have_free_reg, have_free_next;
    logic [IDX_W-1:0] free_reg,      free_next;
    action_t          act_reg,       act_next;
    logic [IDX_W-1:0] slot_reg,      slot_next;
    logic             done_reg,      done_next;
    result_t          result_reg,    result_next;

    logic    rd_en;
    tbl_rd_t rd;
    tbl_wr_t wr;

    dvrtu_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (ptr_reg[IDX_W-1:0]),
        .rd      (rd),
        .wr      (wr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            rd_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= rd_vld_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        ptr_reg       <= ptr_next;
        rd_idx_reg    <= rd_idx_next;
        have_free_reg <= have_free_next;
        free_reg      <= free_next;
        act_reg       <= act_next;
        slot_reg      <= slot_next;
        result_reg    <= result_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        ptr_next       = ptr_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = ptr_reg[IDX_W-1:0];
        have_free_next = have_free_reg;
        free_next      = free_reg;
        act_next       = act_reg;
        slot_next      = slot_reg;
        done_next      = 1'b0;
        result_next    = result_reg;
        rd_en          = 1'b0;
        wr.en          = 1'b0;
        wr.addr        = slot_reg;
        wr.network     = item_reg.route_network;
        wr.mask        = item_reg.route_mask;
        wr.gateway     = item_reg.route_next_hop;
        wr.metric      = item_reg.route_metric[METRIC_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    item_next      = route;
                    ptr_next       = '0;
                    have_free_next = 1'b0;
                    slot_next      = '0;
                    if (route.route_network == LOOPBACK_NET)
                    begin
                        act_next   = ACT_LOOPBACK;
                        state_next = ST_FINISH;
                    end
                    else if (route.route_metric > METRIC_LIMIT)
                    begin
                        act_next   = ACT_BAD_METRIC;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // issue the next read while the previous entry is compared
                if (ptr_reg < PTR_END)
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    ptr_next    = ptr_reg + CNT_W'(1);
                end
                if (rd_vld_reg)
                begin
                    if (rd.valid && rd.network == item_reg.route_network)
                    begin
                        act_next   = (item_reg.route_metric[METRIC_W-1:0] < rd.metric)
                                     ? ACT_REPLACED : ACT_WORSE;
                        slot_next  = rd_idx_reg;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        if (!rd.valid && !have_free_reg)
                        begin
                            have_free_next = 1'b1;
                            free_next      = rd_idx_reg;
                        end
                        if (rd_idx_reg == LAST_IDX)
                        begin
                            if (have_free_reg || !rd.valid)
                            begin
                                act_next  = ACT_ADDED;
                                slot_next = have_free_reg ? free_reg : rd_idx_reg;
                            end
                            else
                            begin
                                act_next  = ACT_FULL;
                                slot_next = '0;
                            end
                            state_next = ST_FINISH;
                        end
                    end
                end
            end

            ST_FINISH:
            begin
                wr.en       = (act_reg == ACT_ADDED) || (act_reg == ACT_REPLACED);
                done_next   = 1'b1;
                result_next = '{action: act_reg, slot: SLOT_W'(slot_reg)};
                state_next  = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_FINISH))
        else $error("result strobe without a finishing step");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy)
        else $error("result strobe while an item is still in work");

    a_zero_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (result_reg.action == ACT_LOOPBACK ||
                      result_reg.action == ACT_BAD_METRIC ||
                      result_reg.action == ACT_FULL)) |-> (result_reg.slot == '0))
        else $error("refused item reports a non-zero slot");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (ptr_reg <= PTR_END))
        else $error("scan pointer ran past the table");

    a_write_only_finish: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == ST_FINISH))
        else $error("table written outside the finishing step");

endmodule

`default_nettype wire
